// ----- hw/rtl/ecd_pkg.sv -----
// Package with the word types, constants and month table for the epoch-to-date converter.
package ecd_pkg;

    localparam logic [31:0] SECS_PER_DAY  = 32'd86400;
    localparam logic [31:0] SECS_PER_HOUR = 32'd3600;
    localparam logic [31:0] SECS_PER_MIN  = 32'd60;
    localparam logic [11:0] BASE_YEAR     = 12'd1970;
    localparam logic [6:0]  BASE_YEAR_100 = 7'd70;
    localparam logic [8:0]  BASE_YEAR_400 = 9'd370;
    localparam logic [3:0]  MONTH_JAN     = 4'd1;
    localparam logic [3:0]  MONTH_FEB     = 4'd2;
    localparam logic [3:0]  MONTH_DEC     = 4'd12;

    typedef struct packed {
        logic [31:0] epoch_seconds;
    } t_in_word;

    typedef struct packed {
        logic [11:0] year;
        logic [3:0]  month;
        logic [4:0]  day;
        logic [4:0]  hour;
        logic [5:0]  minute;
        logic [5:0]  second;
    } t_out_word;

    function automatic logic [4:0] month_len(input logic [3:0] month, input logic leap);
        logic [4:0] len;
        case (month)
            4'd1:    len = 5'd31;
            4'd2:    len = leap ? 5'd29 : 5'd28;
            4'd3:    len = 5'd31;
            4'd4:    len = 5'd30;
            4'd5:    len = 5'd31;
            4'd6:    len = 5'd30;
            4'd7:    len = 5'd31;
            4'd8:    len = 5'd31;
            4'd9:    len = 5'd30;
            4'd10:   len = 5'd31;
            4'd11:   len = 5'd30;
            4'd12:   len = 5'd31;
            default: len = 5'd31;
        endcase
        return len;
    endfunction

endpackage

// ----- hw/rtl/ecd_stream_if.sv -----
// Valid/ready stream interface that carries one word of a given payload type.
interface ecd_stream_if #(parameter type t_payload = logic);
    logic     valid;
    logic     ready;
    t_payload payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

// ----- hw/rtl/epoch_seconds_to_calendar_date.sv -----
// Epoch seconds to UTC calendar date and time of day.
//
// Input channel i_in takes one word holding a 32-bit count of seconds since
// 1970-01-01 00:00:00. Output channel o_out gives one word per input with
// year, month, day, hour, minute and second.
// Both channels use valid/ready; a word moves when both are high.
// A single 33-bit compare-and-subtract unit does all the arithmetic under a
// small sequencer: it finds the day count, the hour and the minute bit by bit,
// then steps through the years from 1970 and then through the months one at a
// time. Once a result is in the output register, the input is ready again.
// The input is ready only while the sequencer is idle; one word is in work
// at a time. A finished result sits in an output register, so the next word
// is accepted while the receiver has not yet taken the previous result.
// If the receiver stalls and the output register is still full when the next
// result is done, the sequencer holds until the register is taken.
// Reset clears the sequencer and the output valid flag.
module epoch_seconds_to_calendar_date
    import ecd_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    ecd_stream_if.sink        i_in,
    ecd_stream_if.source      o_out
);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_DAY   = 3'd1;
    localparam logic [2:0] S_HOUR  = 3'd2;
    localparam logic [2:0] S_MIN   = 3'd3;
    localparam logic [2:0] S_YEAR  = 3'd4;
    localparam logic [2:0] S_MONTH = 3'd5;

    logic [2:0]  r_state, n_state;
    logic [3:0]  r_k, n_k;
    logic [31:0] r_rem, n_rem;
    logic [15:0] r_days, n_days;
    logic [4:0]  r_hour, n_hour;
    logic [5:0]  r_min, n_min;
    logic [11:0] r_year, n_year;
    logic [6:0]  r_y100, n_y100;
    logic [8:0]  r_y400, n_y400;
    logic [3:0]  r_month, n_month;
    logic        r_out_valid, n_out_valid;
    t_out_word   r_out, n_out;

    logic [31:0] alu_a, alu_b;
    logic [32:0] alu_diff;
    logic        alu_ge;
    logic        leap;

    assign leap = ((r_year[1:0] == 2'd0) && (r_y100 != 7'd0)) || (r_y400 == 9'd0);

    always_comb begin
        alu_a = r_rem;
        alu_b = 32'd0;
        unique case (r_state)
            S_DAY:   alu_b = SECS_PER_DAY << r_k;
            S_HOUR:  alu_b = SECS_PER_HOUR << r_k;
            S_MIN:   alu_b = SECS_PER_MIN << r_k;
            S_YEAR: begin
                alu_a = {16'd0, r_days};
                alu_b = leap ? 32'd366 : 32'd365;
            end
            S_MONTH: begin
                alu_a = {16'd0, r_days};
                alu_b = {27'd0, month_len(r_month, leap)};
            end
            default: alu_b = 32'd0;
        endcase
    end

    assign alu_diff = {1'b0, alu_a} - {1'b0, alu_b};
    assign alu_ge   = !alu_diff[32];

    always_comb begin
        n_state     = r_state;
        n_k         = r_k;
        n_rem       = r_rem;
        n_days      = r_days;
        n_hour      = r_hour;
        n_min       = r_min;
        n_year      = r_year;
        n_y100      = r_y100;
        n_y400      = r_y400;
        n_month     = r_month;
        n_out       = r_out;
        n_out_valid = r_out_valid && !o_out.ready;

        unique case (r_state)
            S_IDLE: begin
                if (i_in.valid) begin
                    n_rem   = i_in.payload.epoch_seconds;
                    n_k     = 4'd15;
                    n_state = S_DAY;
                end
            end
            S_DAY: begin
                if (alu_ge) begin
                    n_rem = alu_diff[31:0];
                end
                n_days = {r_days[14:0], alu_ge};
                n_k    = r_k - 4'd1;
                if (r_k == 4'd0) begin
                    n_k     = 4'd4;
                    n_state = S_HOUR;
                end
            end
            S_HOUR: begin
                if (alu_ge) begin
                    n_rem = alu_diff[31:0];
                end
                n_hour = {r_hour[3:0], alu_ge};
                n_k    = r_k - 4'd1;
                if (r_k == 4'd0) begin
                    n_k     = 4'd5;
                    n_state = S_MIN;
                end
            end
            S_MIN: begin
                if (alu_ge) begin
                    n_rem = alu_diff[31:0];
                end
                n_min = {r_min[4:0], alu_ge};
                n_k   = r_k - 4'd1;
                if (r_k == 4'd0) begin
                    n_year  = BASE_YEAR;
                    n_y100  = BASE_YEAR_100;
                    n_y400  = BASE_YEAR_400;
                    n_state = S_YEAR;
                end
            end
            S_YEAR: begin
                if (alu_ge) begin
                    n_days = alu_diff[15:0];
                    n_year = r_year + 12'd1;
                    n_y100 = (r_y100 == 7'd99) ? 7'd0 : r_y100 + 7'd1;
                    n_y400 = (r_y400 == 9'd399) ? 9'd0 : r_y400 + 9'd1;
                end else begin
                    n_month = MONTH_JAN;
                    n_state = S_MONTH;
                end
            end
            S_MONTH: begin
                if (alu_ge && (r_month != MONTH_DEC)) begin
                    n_days  = alu_diff[15:0];
                    n_month = r_month + 4'd1;
                end else if (!r_out_valid || o_out.ready) begin
                    n_out.year   = r_year;
                    n_out.month  = r_month;
                    n_out.day    = r_days[4:0] + 5'd1;
                    n_out.hour   = r_hour;
                    n_out.minute = r_min;
                    n_out.second = r_rem[5:0];
                    n_out_valid  = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
        r_k     <= n_k;
        r_rem   <= n_rem;
        r_days  <= n_days;
        r_hour  <= n_hour;
        r_min   <= n_min;
        r_year  <= n_year;
        r_y100  <= n_y100;
        r_y400  <= n_y400;
        r_month <= n_month;
        r_out   <= n_out;
    end

    assign i_in.ready    = (r_state == S_IDLE);
    assign o_out.valid   = r_out_valid;
    assign o_out.payload = r_out;

endmodule
